/* rtl/core/mqtt_frame_checker_defines.svh */
// Assertion macros shared by the MQTT frame checker RTL.
// Each macro takes a label, a condition pair and a message; clock and reset are fixed names.
`ifndef MQTT_FRAME_CHECKER_DEFINES_SVH
`define MQTT_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MFC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mfc_pkg.sv */
// Shared types, codes and lookup functions for the MQTT frame checker.
// No dependencies; every RTL module of the block imports this package.
`default_nettype none

package mfc_pkg;

   // Parser phases, one-hot.
   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_LENGTH  = 4'b0010,
      PH_BODY    = 4'b0100,
      PH_DISCARD = 4'b1000
   } phase_type;

   // Frame status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_FLAGS = 2'd1;
   localparam logic [1:0] ST_RESERVED  = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   // MQTT control packet types.
   localparam logic [3:0] PT_RESERVED_LO = 4'd0;
   localparam logic [3:0] PT_CONNECT     = 4'd1;
   localparam logic [3:0] PT_CONNACK     = 4'd2;
   localparam logic [3:0] PT_PUBLISH     = 4'd3;
   localparam logic [3:0] PT_PUBACK      = 4'd4;
   localparam logic [3:0] PT_PUBREC      = 4'd5;
   localparam logic [3:0] PT_PUBREL      = 4'd6;
   localparam logic [3:0] PT_PUBCOMP     = 4'd7;
   localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
   localparam logic [3:0] PT_SUBACK      = 4'd9;
   localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
   localparam logic [3:0] PT_UNSUBACK    = 4'd11;
   localparam logic [3:0] PT_PINGREQ     = 4'd12;
   localparam logic [3:0] PT_PINGRESP    = 4'd13;
   localparam logic [3:0] PT_DISCONNECT  = 4'd14;
   localparam logic [3:0] PT_RESERVED_HI = 4'd15;

   // Flag values required by the fixed header.
   localparam logic [3:0] FLAGS_NONE = 4'h0;
   localparam logic [3:0] FLAGS_QOS1 = 4'h2;

   // Remaining-length encoding.
   localparam int         LEN_MAX_BYTES = 4;
   localparam logic [27:0] LEN_ZERO     = 28'd0;

   // CONNECT variable header offsets within the body.
   localparam logic [3:0] OFS_LEN_HI      = 4'd0;
   localparam logic [3:0] OFS_LEN_LO      = 4'd1;
   localparam logic [3:0] OFS_NAME        = 4'd2;
   localparam logic [3:0] OFS_SHORT_LEVEL = 4'd6;
   localparam logic [3:0] OFS_LONG_LEVEL  = 4'd8;
   localparam logic [3:0] OFS_SATURATE    = 4'd9;

   // Protocol name lengths and levels.
   localparam logic [15:0] NAME_LEN_SHORT = 16'd4;
   localparam logic [15:0] NAME_LEN_LONG  = 16'd6;
   localparam logic [7:0]  LEVEL_SHORT    = 8'h04;
   localparam logic [7:0]  LEVEL_LONG     = 8'h03;

   // One result as it travels from the parser to the output queue.
   typedef struct packed {
      logic [3:0]  packet_kind;
      logic [3:0]  packet_flags;
      logic [27:0] remaining_length;
      logic [1:0]  frame_status;
      logic        connect_name_ok;
   } result_type;

   // Character of the protocol name "MQTT".
   function automatic logic [7:0] name_short_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h4D;
         3'd1:    c = 8'h51;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h54;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Character of the protocol name "MQIsdp".
   function automatic logic [7:0] name_long_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h4D;
         3'd1:    c = 8'h51;
         3'd2:    c = 8'h49;
         3'd3:    c = 8'h73;
         3'd4:    c = 8'h64;
         3'd5:    c = 8'h70;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Fixed-header flag check by packet type.
   function automatic logic [1:0] check_type(input logic [3:0] ptype,
                                             input logic [3:0] flags);
      logic [1:0] st;
      case (ptype)
         PT_CONNECT, PT_CONNACK, PT_PUBACK, PT_PUBREC, PT_PUBCOMP,
         PT_SUBACK, PT_UNSUBACK, PT_PINGREQ, PT_PINGRESP, PT_DISCONNECT:
            st = (flags != FLAGS_NONE) ? ST_BAD_FLAGS : ST_OK;
         PT_PUBREL, PT_SUBSCRIBE, PT_UNSUBSCRIBE:
            st = (flags != FLAGS_QOS1) ? ST_BAD_FLAGS : ST_OK;
         PT_PUBLISH:
            st = ST_OK;
         default:
            st = ST_RESERVED;
      endcase
      return st;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/mfc_parser.sv */
// Per-byte MQTT fixed-header parser: state registers and the next-state logic.
// Depends on mfc_pkg and the assertion macros in mqtt_frame_checker_defines.svh.
`default_nettype none
`include "mqtt_frame_checker_defines.svh"

module mfc_parser
   import mfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] data_byte,
   input  wire logic       chunk_start,
   output logic            result_valid,
   output result_type      result
);

   phase_type   phase_ff, phase_in, phase_cur;
   logic [3:0]  held_type_ff, held_type_in;
   logic [3:0]  held_flags_ff, held_flags_in;
   logic [27:0] acc_ff, acc_in;
   logic [2:0]  len_count_ff, len_count_in;
   logic [27:0] body_left_ff, body_left_in;
   logic [3:0]  body_offset_ff, body_offset_in;
   logic [15:0] name_len_ff, name_len_in;
   logic        short_match_ff, short_match_in;
   logic        long_match_ff, long_match_in;
   logic        connect_valid_ff, connect_valid_in;

   logic [27:0] len_digit;
   logic [27:0] acc_sum;
   logic [27:0] body_left_dec;
   logic [3:0]  name_idx;
   logic [1:0]  type_status;

   // Current length byte placed at its base-128 digit position.
   always_comb begin
      case (len_count_ff[1:0])
         2'd0:    len_digit = {21'd0, data_byte[6:0]};
         2'd1:    len_digit = {14'd0, data_byte[6:0], 7'd0};
         2'd2:    len_digit = {7'd0, data_byte[6:0], 14'd0};
         2'd3:    len_digit = {data_byte[6:0], 21'd0};
         default: len_digit = LEN_ZERO;
      endcase
   end

   // Higher digits of the accumulator are still zero, so an OR adds the digit.
   assign acc_sum       = acc_ff | len_digit;
   assign body_left_dec = body_left_ff - 28'd1;
   assign name_idx      = body_offset_ff - OFS_NAME;
   assign type_status   = check_type(held_type_ff, held_flags_ff);

   // A chunk start forces the byte to be taken as a frame header.
   assign phase_cur = chunk_start ? PH_HEADER : phase_ff;

   // Next state and result for one byte.
   always_comb begin
      phase_in         = phase_ff;
      held_type_in     = held_type_ff;
      held_flags_in    = held_flags_ff;
      acc_in           = acc_ff;
      len_count_in     = len_count_ff;
      body_left_in     = body_left_ff;
      body_offset_in   = body_offset_ff;
      name_len_in      = name_len_ff;
      short_match_in   = short_match_ff;
      long_match_in    = long_match_ff;
      connect_valid_in = connect_valid_ff;

      result_valid            = 1'b0;
      result.packet_kind      = held_type_ff;
      result.packet_flags     = held_flags_ff;
      result.remaining_length = acc_sum;
      result.frame_status     = ST_OK;
      result.connect_name_ok  = 1'b0;

      case (phase_cur)
         PH_HEADER: begin
            held_type_in     = data_byte[7:4];
            held_flags_in    = data_byte[3:0];
            acc_in           = LEN_ZERO;
            len_count_in     = 3'd0;
            body_left_in     = LEN_ZERO;
            body_offset_in   = OFS_LEN_HI;
            name_len_in      = 16'd0;
            short_match_in   = 1'b1;
            long_match_in    = 1'b1;
            connect_valid_in = 1'b0;
            phase_in         = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (len_count_ff == 3'(LEN_MAX_BYTES)) begin
               // A fifth length byte is malformed whatever its value.
               phase_in                = PH_DISCARD;
               result_valid            = 1'b1;
               result.remaining_length = acc_ff;
               result.frame_status     = ST_MALFORMED;
            end else begin
               acc_in       = acc_sum;
               len_count_in = len_count_ff + 3'd1;
               if (!data_byte[7]) begin
                  if (acc_sum == LEN_ZERO) begin
                     // Empty body: the frame ends here, flags unchecked.
                     phase_in     = PH_HEADER;
                     result_valid = 1'b1;
                  end else if (type_status != ST_OK) begin
                     phase_in            = PH_DISCARD;
                     result_valid        = 1'b1;
                     result.frame_status = type_status;
                  end else begin
                     body_left_in = acc_sum;
                     phase_in     = PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            // CONNECT protocol name and level check over the first body bytes.
            if (held_type_ff == PT_CONNECT && body_offset_ff < OFS_SATURATE) begin
               if (body_offset_ff == OFS_LEN_HI) begin
                  name_len_in = {data_byte, 8'd0};
               end else if (body_offset_ff == OFS_LEN_LO) begin
                  name_len_in = name_len_ff | {8'd0, data_byte};
               end else begin
                  if (body_offset_ff < OFS_SHORT_LEVEL &&
                      data_byte != name_short_char(name_idx[2:0])) begin
                     short_match_in = 1'b0;
                  end
                  if (body_offset_ff < OFS_LONG_LEVEL &&
                      data_byte != name_long_char(name_idx[2:0])) begin
                     long_match_in = 1'b0;
                  end
                  if (body_offset_ff == OFS_SHORT_LEVEL && name_len_ff == NAME_LEN_SHORT &&
                      short_match_ff && data_byte == LEVEL_SHORT) begin
                     connect_valid_in = 1'b1;
                  end
                  if (body_offset_ff == OFS_LONG_LEVEL && name_len_ff == NAME_LEN_LONG &&
                      long_match_ff && data_byte == LEVEL_LONG) begin
                     connect_valid_in = 1'b1;
                  end
               end
            end
            if (body_offset_ff < OFS_SATURATE) begin
               body_offset_in = body_offset_ff + 4'd1;
            end
            body_left_in = body_left_dec;
            if (body_left_dec == LEN_ZERO) begin
               phase_in                = PH_HEADER;
               result_valid            = 1'b1;
               result.remaining_length = acc_ff;
               result.connect_name_ok  = (held_type_ff == PT_CONNECT) & connect_valid_in;
            end
         end
         default: begin
            // Discarding until the next chunk start.
         end
      endcase
   end

   // State registers, updated only when a byte is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         held_type_ff     <= 4'd0;
         held_flags_ff    <= 4'd0;
         acc_ff           <= LEN_ZERO;
         len_count_ff     <= 3'd0;
         body_left_ff     <= LEN_ZERO;
         body_offset_ff   <= OFS_LEN_HI;
         name_len_ff      <= 16'd0;
         short_match_ff   <= 1'b1;
         long_match_ff    <= 1'b1;
         connect_valid_ff <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         held_type_ff     <= held_type_in;
         held_flags_ff    <= held_flags_in;
         acc_ff           <= acc_in;
         len_count_ff     <= len_count_in;
         body_left_ff     <= body_left_in;
         body_offset_ff   <= body_offset_in;
         name_len_ff      <= name_len_in;
         short_match_ff   <= short_match_in;
         long_match_ff    <= long_match_in;
         connect_valid_ff <= connect_valid_in;
      end
   end

   // Parser invariants.
   `MFC_ASSERT_NOW(a_body_nonempty, phase_ff == PH_BODY, body_left_ff != LEN_ZERO, "empty body")
   `MFC_ASSERT_NOW(a_len_count_max, 1'b1, len_count_ff <= 3'(LEN_MAX_BYTES), "length count")
   `MFC_ASSERT_NEXT(a_hold_when_idle, !advance, $stable(phase_ff) && $stable(acc_ff), "idle move")

endmodule

`default_nettype wire

/* rtl/core/mfc_rsp_queue.sv */
// Two-entry result queue that decouples the parser from the response channel.
// Depends on mfc_pkg and the assertion macros in mqtt_frame_checker_defines.svh.
`default_nettype none
`include "mqtt_frame_checker_defines.svh"

module mfc_rsp_queue
   import mfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire result_type  push_data,
   output logic             full,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       head
);

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign head      = slot0_ff;

   // Slot 0 is always the oldest request; slot 1 only fills while stalled.
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               slot0_in = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               slot0_in = push_data;
            end else if (push) begin
               slot1_in = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               slot0_in = slot1_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   // Occupancy is control state; the slots carry payload only.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Queue checks.
   `MFC_ASSERT_NOW(a_no_overflow, full, !push, "push into a full result queue")
   `MFC_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 2'd1, "queue count did not grow on push")

endmodule

`default_nettype wire

/* rtl/core/mqtt_frame_checker.sv */
// MQTT frame checker top level: input register, parser and result queue.
// Depends on mfc_pkg, mfc_parser and mfc_rsp_queue.
//
// Usage:
//   The request channel (req_valid/req_ready) carries one byte of a
//   client-to-server MQTT stream per request, with req_chunk_start set on
//   the first byte of a chunk. The response channel (rsp_valid/rsp_ready)
//   carries one result per complete frame or per detected error: type,
//   flags, decoded remaining length, status and the CONNECT name flag.
//   Bytes that complete no frame produce no response.
//   Throughput is one byte per clock cycle while the queue has room. A
//   byte is registered in the input register at acceptance and is parsed
//   once the result queue has room; its result is then written into the
//   queue, whose head drives the response channel.
//   The parser state advances once per byte; the two-entry result queue
//   lets a new byte be accepted while a finished result waits. When the
//   receiver stalls the queue fills and req_ready drops until a slot frees.
//   Reset (synchronous, active high) empties the pipeline and the queue and
//   puts the parser at a frame header.
`default_nettype none

module mqtt_frame_checker
   import mfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_chunk_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_packet_kind,
   output logic [3:0]       rsp_packet_flags,
   output logic [27:0]      rsp_remaining_length,
   output logic [1:0]       rsp_frame_status,
   output logic             rsp_connect_name_ok
);

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff;
   logic       stage_chunk_ff;
   logic       queue_full;
   logic       advance;
   logic       result_valid;
   result_type result;
   result_type head;

   // The staged byte moves on whenever the queue has room for its result.
   assign advance        = stage_valid_ff && !queue_full;
   assign req_ready      = !stage_valid_ff || !queue_full;
   assign stage_valid_in = (req_valid && req_ready) || (stage_valid_ff && !advance);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_byte_ff  <= req_data_byte;
         stage_chunk_ff <= req_chunk_start;
      end
   end

   // Frame parser.
   mfc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .data_byte    (stage_byte_ff),
      .chunk_start  (stage_chunk_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // Result register and skid slot.
   mfc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && result_valid),
      .push_data (result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_packet_kind      = head.packet_kind;
   assign rsp_packet_flags     = head.packet_flags;
   assign rsp_remaining_length = head.remaining_length;
   assign rsp_frame_status     = head.frame_status;
   assign rsp_connect_name_ok  = head.connect_name_ok;

endmodule

`default_nettype wire

/* bench/mfc_frame_monitor.sv */
// Response checker for the MQTT frame checker: tracks the fixed-header parse of every
// accepted request byte, queues the predicted results and compares each accepted response.
// Depends on mfc_pkg for the phase enum, status codes, packet types and the result struct.
module mfc_frame_monitor
   import mfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_chunk_start,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [3:0]  rsp_packet_kind,
   input  wire logic [3:0]  rsp_packet_flags,
   input  wire logic [27:0] rsp_remaining_length,
   input  wire logic [1:0]  rsp_frame_status,
   input  wire logic        rsp_connect_name_ok,
   output int               mismatch_count,
   output int               frames_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Protocol names as packed byte strings; index 0 is the first character.
   localparam logic [0:3][7:0] NAME_MQTT   = "MQTT";
   localparam logic [0:5][7:0] NAME_MQISDP = "MQIsdp";

   // Shadow copy of the parser state.
   phase_type   frame_phase = PH_HEADER;
   logic [3:0]  hdr_type = '0;
   logic [3:0]  hdr_flags = '0;
   logic [27:0] len_acc = '0;
   logic [2:0]  len_count = '0;
   logic [27:0] body_left = '0;
   logic [3:0]  body_pos = '0;
   logic [15:0] proto_name_len = '0;
   logic        mqtt_match = 1'b1;
   logic        mqisdp_match = 1'b1;
   logic        connect_ok = 1'b0;

   result_type  expected_frames[$];
   int          error_total = 0;

   // Clears everything that belongs to one frame.
   function automatic void clear_frame_state();
      len_acc = '0;
      len_count = '0;
      body_left = '0;
      body_pos = '0;
      proto_name_len = '0;
      mqtt_match = 1'b1;
      mqisdp_match = 1'b1;
      connect_ok = 1'b0;
   endfunction

   function automatic result_type frame_result(input logic [1:0] status, input logic name_ok);
      result_type r;
      r.packet_kind      = hdr_type;
      r.packet_flags     = hdr_flags;
      r.remaining_length = len_acc;
      r.frame_status     = status;
      r.connect_name_ok  = name_ok;
      return r;
   endfunction

   // Advances the shadow parser by one byte and reports the result it causes, if any.
   task automatic parse_byte(input logic [7:0] b, input logic cs,
                             output logic hit, output result_type res);
      logic [1:0] st;
      logic [3:0] name_idx;
      hit = 1'b0;
      res = '0;
      if (cs) frame_phase = PH_HEADER;
      case (frame_phase)
         PH_HEADER: begin
            hdr_type = b[7:4];
            hdr_flags = b[3:0];
            clear_frame_state();
            frame_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (len_count == 3'(LEN_MAX_BYTES)) begin
               // A fifth length byte is malformed whatever it holds.
               frame_phase = PH_DISCARD;
               hit = 1'b1;
               res = frame_result(ST_MALFORMED, 1'b0);
            end else begin
               len_acc = len_acc + (28'(b[6:0]) << (7 * len_count));
               len_count++;
               if (!b[7]) begin
                  if (len_acc == LEN_ZERO) begin
                     // An empty frame ends here and its header is not checked.
                     frame_phase = PH_HEADER;
                     hit = 1'b1;
                     res = frame_result(ST_OK, 1'b0);
                  end else begin
                     case (hdr_type)
                        PT_CONNECT, PT_CONNACK, PT_PUBACK, PT_PUBREC, PT_PUBCOMP,
                        PT_SUBACK, PT_UNSUBACK, PT_PINGREQ, PT_PINGRESP, PT_DISCONNECT:
                           st = (hdr_flags == FLAGS_NONE) ? ST_OK : ST_BAD_FLAGS;
                        PT_PUBREL, PT_SUBSCRIBE, PT_UNSUBSCRIBE:
                           st = (hdr_flags == FLAGS_QOS1) ? ST_OK : ST_BAD_FLAGS;
                        PT_PUBLISH:
                           st = ST_OK;
                        default:
                           st = ST_RESERVED;
                     endcase
                     if (st != ST_OK) begin
                        frame_phase = PH_DISCARD;
                        hit = 1'b1;
                        res = frame_result(st, 1'b0);
                     end else begin
                        body_left = len_acc;
                        frame_phase = PH_BODY;
                     end
                  end
               end
            end
         end
         PH_BODY: begin
            // CONNECT bodies carry the protocol name length, the name and the level.
            if (hdr_type == PT_CONNECT && body_pos < OFS_SATURATE) begin
               if (body_pos == OFS_LEN_HI) begin
                  proto_name_len = {b, 8'h00};
               end else if (body_pos == OFS_LEN_LO) begin
                  proto_name_len[7:0] = b;
               end else begin
                  name_idx = body_pos - OFS_NAME;
                  if (body_pos < OFS_SHORT_LEVEL && b != NAME_MQTT[name_idx])
                     mqtt_match = 1'b0;
                  if (body_pos < OFS_LONG_LEVEL && b != NAME_MQISDP[name_idx])
                     mqisdp_match = 1'b0;
                  if (body_pos == OFS_SHORT_LEVEL && proto_name_len == NAME_LEN_SHORT &&
                      mqtt_match && b == LEVEL_SHORT)
                     connect_ok = 1'b1;
                  if (body_pos == OFS_LONG_LEVEL && proto_name_len == NAME_LEN_LONG &&
                      mqisdp_match && b == LEVEL_LONG)
                     connect_ok = 1'b1;
               end
            end
            if (body_pos < OFS_SATURATE) body_pos++;
            body_left--;
            if (body_left == LEN_ZERO) begin
               frame_phase = PH_HEADER;
               hit = 1'b1;
               res = frame_result(ST_OK, (hdr_type == PT_CONNECT) ? connect_ok : 1'b0);
            end
         end
         default: ;
      endcase
   endtask

   // Compare accepted responses against the oldest prediction, then predict from the request.
   always @(posedge clock) begin : track
      logic       hit;
      result_type want;
      if (reset) begin
         frame_phase = PH_HEADER;
         hdr_type = '0;
         hdr_flags = '0;
         clear_frame_state();
         expected_frames.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("response with no frame waiting: type %0h status %0d",
                      rsp_packet_kind, rsp_frame_status);
               error_total++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_packet_kind !== want.packet_kind) begin
                  $error("packet_kind: expected %0h, got %0h",
                         want.packet_kind, rsp_packet_kind);
                  error_total++;
               end
               if (rsp_packet_flags !== want.packet_flags) begin
                  $error("packet_flags: expected %0h, got %0h",
                         want.packet_flags, rsp_packet_flags);
                  error_total++;
               end
               if (rsp_remaining_length !== want.remaining_length) begin
                  $error("remaining_length: expected %0d, got %0d",
                         want.remaining_length, rsp_remaining_length);
                  error_total++;
               end
               if (rsp_frame_status !== want.frame_status) begin
                  $error("frame_status: expected %0d, got %0d",
                         want.frame_status, rsp_frame_status);
                  error_total++;
               end
               if (rsp_connect_name_ok !== want.connect_name_ok) begin
                  $error("connect_name_ok: expected %0b, got %0b",
                         want.connect_name_ok, rsp_connect_name_ok);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte, req_chunk_start, hit, want);
            if (hit) expected_frames.push_back(want);
         end
      end
      mismatch_count <= error_total;
      frames_pending <= expected_frames.size();
   end

endmodule

/* bench/tb_mqtt_frame_checker.sv */
// Top of the MQTT frame checker bench: clock, reset, byte-stream stimulus and verdict.
// Depends on mfc_pkg, the mqtt_frame_checker RTL and the mfc_frame_monitor checker.
module tb_mqtt_frame_checker;
   timeunit 1ns;
   timeprecision 1ps;
   import mfc_pkg::*;

   localparam int RANDOM_BYTES   = 500;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_chunk_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_packet_kind;
   logic [3:0]  rsp_packet_flags;
   logic [27:0] rsp_remaining_length;
   logic [1:0]  rsp_frame_status;
   logic        rsp_connect_name_ok;

   int          mismatch_count;
   int          frames_pending;
   int          req_idle_pct = 15;
   int          rsp_stall_pct = 45;
   int          bytes_accepted = 0;
   int          stall_cycles = 0;

   logic [7:0]  frame_buf[$];
   logic [7:0]  body_buf[$];

   always #2 clock = ~clock;

   mqtt_frame_checker u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_chunk_start      (req_chunk_start),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_packet_kind      (rsp_packet_kind),
      .rsp_packet_flags     (rsp_packet_flags),
      .rsp_remaining_length (rsp_remaining_length),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_connect_name_ok  (rsp_connect_name_ok)
   );

   mfc_frame_monitor u_monitor (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_chunk_start      (req_chunk_start),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_packet_kind      (rsp_packet_kind),
      .rsp_packet_flags     (rsp_packet_flags),
      .rsp_remaining_length (rsp_remaining_length),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_connect_name_ok  (rsp_connect_name_ok),
      .mismatch_count       (mismatch_count),
      .frames_pending       (frames_pending)
   );

   // The receiver stalls at random with the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Ends the run if neither channel moves a request for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offers one byte, with random idle cycles in front, and waits for its request.
   task automatic send_byte(input logic [7:0] value, input logic chunk_start);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_chunk_start <= chunk_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_accepted++;
   endtask

   // Holds the sender off until every predicted response has been accepted.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
   endtask

   // Header flags that pass the per-type check.
   function automatic logic [3:0] legal_flags(input logic [3:0] ptype);
      logic [3:0] f;
      case (ptype)
         PT_PUBREL, PT_SUBSCRIBE, PT_UNSUBSCRIBE: f = FLAGS_QOS1;
         PT_PUBLISH:                              f = 4'($urandom);
         default:                                 f = FLAGS_NONE;
      endcase
      return f;
   endfunction

   // Encodes a small length in one to four bytes, padding with zero continuation bytes.
   task automatic push_length(input int value, input int nbytes);
      if (nbytes == 1) begin
         frame_buf.push_back(8'(value));
      end else begin
         frame_buf.push_back(8'(value) | 8'h80);
         repeat (nbytes - 2) frame_buf.push_back(8'h80);
         frame_buf.push_back(8'h00);
      end
   endtask

   // Builds and sends one random frame; broken tells the caller to restart the next chunk.
   task automatic send_random_frame(input bit start, output bit broken);
      int         kind;
      int         variant;
      int         keep;
      bit         framed;
      bit         noisy;
      logic [3:0] ptype;
      logic [3:0] pflags;
      frame_buf.delete();
      body_buf.delete();
      broken = 1'b0;
      framed = 1'b1;
      kind = $urandom_range(99);
      noisy = ($urandom_range(99) < 4) || (kind >= 95);
      ptype = PT_CONNECT;
      pflags = FLAGS_NONE;
      if (kind < 25) begin
         // CONNECT with a right, damaged, random or truncated protocol name.
         variant = $urandom_range(7);
         if ($urandom_range(9) == 0) begin
            pflags = 4'($urandom);
            broken = 1'b1;
         end
         if (variant < 4) begin
            body_buf = '{8'h00, 8'h04, "M", "Q", "T", "T", LEVEL_SHORT};
            if (variant == 3) body_buf[6] = 8'($urandom);
         end else if (variant < 6) begin
            body_buf = '{8'h00, 8'h06, "M", "Q", "I", "s", "d", "p", LEVEL_LONG};
            if (variant == 5) body_buf[$urandom_range(8)] ^= 8'(1 << $urandom_range(7));
         end else if (variant == 6) begin
            repeat ($urandom_range(9)) body_buf.push_back(8'($urandom));
         end else begin
            if ($urandom_range(1) == 0)
               body_buf = '{8'h00, 8'h04, "M", "Q", "T", "T", LEVEL_SHORT};
            else
               body_buf = '{8'h00, 8'h06, "M", "Q", "I", "s", "d", "p", LEVEL_LONG};
            keep = $urandom_range(1, body_buf.size() - 1);
            while (body_buf.size() > keep) void'(body_buf.pop_back());
         end
         if (variant < 6) repeat ($urandom_range(4)) body_buf.push_back(8'($urandom));
      end else if (kind < 65) begin
         // Well-formed frame of any other defined type, sometimes empty.
         ptype = 4'($urandom_range(2, 14));
         pflags = legal_flags(ptype);
         if ($urandom_range(7) != 0)
            repeat ($urandom_range(1, 10)) body_buf.push_back(8'($urandom));
      end else if (kind < 80) begin
         // Arbitrary header with an arbitrary length, then bytes to be discarded.
         framed = 1'b0;
         broken = 1'b1;
         frame_buf.push_back(8'($urandom));
         keep = $urandom_range(1, 4);
         for (int i = 0; i < keep; i++)
            frame_buf.push_back((i < keep - 1) ? (8'($urandom) | 8'h80)
                                               : (8'($urandom) & 8'h7F));
         repeat ($urandom_range(3)) frame_buf.push_back(8'($urandom));
      end else if (kind < 88) begin
         // Length field running into a fifth byte.
         framed = 1'b0;
         broken = 1'b1;
         frame_buf.push_back(8'($urandom));
         repeat (4) frame_buf.push_back(8'($urandom) | 8'h80);
         frame_buf.push_back(8'($urandom));
         repeat ($urandom_range(3)) frame_buf.push_back(8'($urandom));
      end else if (kind < 95) begin
         // Frame that the next chunk start cuts short.
         framed = 1'b0;
         broken = 1'b1;
         ptype = 4'($urandom_range(1, 14));
         frame_buf.push_back({ptype, legal_flags(ptype)});
         keep = $urandom_range(3, 12);
         push_length(keep, 1);
         repeat ($urandom_range(0, keep - 1)) frame_buf.push_back(8'($urandom));
      end else begin
         // Plain noise.
         framed = 1'b0;
         repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom));
      end
      if (framed) begin
         frame_buf.push_back({ptype, pflags});
         push_length(body_buf.size(), ($urandom_range(4) == 0) ? $urandom_range(2, 4) : 1);
         foreach (body_buf[i]) frame_buf.push_back(body_buf[i]);
      end
      if (noisy) broken = 1'b1;
      foreach (frame_buf[i])
         send_byte(frame_buf[i], (i == 0) ? start : (noisy && $urandom_range(3) == 0));
   endtask

   initial begin : stimulus
      bit broken;
      int goal;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // CONNECT carrying "MQTT" at level 4.
      send_byte(8'h10, 1'b1); send_byte(8'h07, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h04, 1'b0); send_byte(8'h4D, 1'b0); send_byte(8'h51, 1'b0);
      send_byte(8'h54, 1'b0); send_byte(8'h54, 1'b0); send_byte(8'h04, 1'b0);
      // Empty DISCONNECT: complete at its length byte.
      send_byte(8'hE0, 1'b0); send_byte(8'h00, 1'b0);
      // PUBLISH whose length runs into a fifth byte.
      send_byte(8'h30, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
      // Reserved type after a chunk start.
      send_byte(8'hF0, 1'b1); send_byte(8'h01, 1'b0);
      // PUBREL with wrong flags.
      send_byte(8'h61, 1'b1); send_byte(8'h01, 1'b0);
      // PINGREQ cut short by the next chunk start, then a good SUBSCRIBE.
      send_byte(8'hC0, 1'b1); send_byte(8'h05, 1'b0); send_byte(8'hAA, 1'b0);
      send_byte(8'h82, 1'b1); send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b0);

      // Three random phases, each opened with the sender held off until all responses are in.
      broken = 1'b0;
      for (int p = 0; p < 3; p++) begin
         drain_responses();
         case (p)
            0: begin
               req_idle_pct = 15;
               rsp_stall_pct <= 45;
            end
            1: begin
               req_idle_pct = 45;
               rsp_stall_pct <= 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_stall_pct <= 0;
            end
         endcase
         goal = bytes_accepted + RANDOM_BYTES / 3;
         while (bytes_accepted < goal)
            send_random_frame(broken || ($urandom_range(1) == 1), broken);
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (frames_pending != 0)
         $error("%0d predicted responses never arrived", frames_pending);
      if (mismatch_count == 0 && frames_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
